@@ src/rau_pkg.sv @@
package rau_pkg;

    // action codes
    localparam logic [2:0] ACT_NORM = 3'd0;
    localparam logic [2:0] ACT_ADD  = 3'd1;
    localparam logic [2:0] ACT_SUB  = 3'd2;
    localparam logic [2:0] ACT_MUL  = 3'd3;
    localparam logic [2:0] ACT_DIV  = 3'd4;
    localparam logic [2:0] ACT_CMP  = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // compare codes
    localparam logic [1:0] ORD_LESS    = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_GREATER = 2'd2;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic [30:0]        b_den;
    } t_rau_in;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic [1:0]         order;
        logic [1:0]         status;
    } t_rau_out;

    // magnitude of a two's complement word, the most negative value included
    function automatic logic [31:0] mag32(input logic [31:0] x);
        return x[31] ? (~x + 32'd1) : x;
    endfunction

endpackage

@@ src/rau_stream_if.sv @@
interface rau_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/rational_arithmetic_unit.sv @@
// Exact arithmetic on signed fractions: normalize, add, subtract, multiply,
// divide and compare, with the result reduced by its greatest common divisor
// and the sign carried in the numerator. One transaction is worked at a time.
// The three 32x32 products come from a bit-serial shift-add multiplier
// (skipped when normalizing), a binary GCD removes one bit per step, and
// two restoring divisions of 64-bit magnitudes by the GCD follow; rejected
// or undefined actions go straight to the output. The input is taken again
// as soon as the result moves into the output register, which holds it
// until the sink takes it.
module rational_arithmetic_unit #(
    parameter int WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rau_stream_if.sink    i_in,
    rau_stream_if.source  o_out
);
    import rau_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MLD  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_COMB = 3'd3;
    localparam logic [2:0] S_GCD  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_CHK  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    localparam logic [63:0] LIM = 64'd1 << (WIDTH - 1);

    logic [2:0]  r_state;
    logic [2:0]  r_act;
    logic [31:0] r_an, r_ad, r_bn;
    logic [30:0] r_bd;
    logic [1:0]  r_k;
    logic [5:0]  r_cnt;
    logic [63:0] r_mcand, r_acc;
    logic [31:0] r_mplier;
    logic        r_msg;
    logic [63:0] r_p0, r_p1, r_p2;
    logic [2:0]  r_sg;
    logic        r_neg;
    logic [63:0] r_nm, r_dm, r_x, r_y, r_g, r_q;
    logic [64:0] r_r;
    logic [5:0]  r_sh;
    logic        r_dsel;
    t_rau_out    r_res;
    logic        r_ovalid;
    t_rau_out    r_odata;

    logic [31:0] w_opa, w_opb;
    logic        w_osg;
    logic [63:0] w_acc_next;
    logic [65:0] w_v0, w_v1, w_v2, w_n, w_d, w_nabs, w_dabs;
    logic [64:0] w_rt, w_rsub;
    logic        w_ge;
    logic [63:0] w_qn;
    logic        w_ovf;
    logic [63:0] w_resn;

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_odata;

    // multiplier operand selection for the current product
    always_comb begin
        unique case (r_k)
            2'd0: begin
                w_opa = mag32(r_an);
                w_opb = (r_act == ACT_MUL) ? mag32(r_bn) : {1'b0, r_bd};
                w_osg = r_an[31] ^ ((r_act == ACT_MUL) & r_bn[31]);
            end
            2'd1: begin
                w_opa = mag32(r_bn);
                w_opb = mag32(r_ad);
                w_osg = r_bn[31] ^ r_ad[31];
            end
            default: begin
                w_opa = mag32(r_ad);
                w_opb = (r_act == ACT_DIV) ? mag32(r_bn) : {1'b0, r_bd};
                w_osg = r_ad[31] ^ ((r_act == ACT_DIV) & r_bn[31]);
            end
        endcase
    end

    assign w_acc_next = r_acc + (r_mplier[0] ? r_mcand : 64'd0);

    // signed numerator and denominator from the products
    assign w_v0 = r_sg[0] ? (66'd0 - {2'b00, r_p0}) : {2'b00, r_p0};
    assign w_v1 = r_sg[1] ? (66'd0 - {2'b00, r_p1}) : {2'b00, r_p1};
    assign w_v2 = r_sg[2] ? (66'd0 - {2'b00, r_p2}) : {2'b00, r_p2};

    always_comb begin
        priority if (r_act == ACT_NORM) begin
            w_n = {{34{r_an[31]}}, r_an};
            w_d = {{34{r_ad[31]}}, r_ad};
        end else if (r_act == ACT_ADD) begin
            w_n = w_v0 + w_v1;
            w_d = w_v2;
        end else if (r_act == ACT_SUB || r_act == ACT_CMP) begin
            w_n = w_v0 - w_v1;
            w_d = w_v2;
        end else begin
            w_n = w_v0;
            w_d = w_v2;
        end
    end

    assign w_nabs = w_n[65] ? (66'd0 - w_n) : w_n;
    assign w_dabs = w_d[65] ? (66'd0 - w_d) : w_d;

    // restoring division step
    assign w_rt   = {r_r[63:0], r_q[63]};
    assign w_ge   = (w_rt >= {1'b0, r_g});
    assign w_rsub = w_rt - {1'b0, r_g};
    assign w_qn   = {r_q[62:0], w_ge};

    // range check of the reduced result
    assign w_ovf  = (r_dm > LIM - 64'd1) || (r_neg ? (r_nm > LIM) : (r_nm > LIM - 64'd1));
    assign w_resn = r_neg ? (64'd0 - r_nm) : r_nm;

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    r_act <= i_in.data.action;
                    r_an  <= i_in.data.a_num;
                    r_ad  <= i_in.data.a_den;
                    r_bn  <= i_in.data.b_num;
                    r_bd  <= i_in.data.b_den;
                    r_k   <= 2'd0;
                    r_res <= '0;
                    priority if (i_in.data.action > ACT_CMP) begin
                        r_state <= S_OUT;
                    end else if (i_in.data.a_den == 32'd0 ||
                                 (i_in.data.action != ACT_NORM && i_in.data.b_den == 31'd0)) begin
                        r_res.status <= ST_ZERO_DEN;
                        r_state      <= S_OUT;
                    end else if (i_in.data.action == ACT_NORM) begin
                        r_state <= S_COMB;
                    end else begin
                        r_state <= S_MLD;
                    end
                end
            end
            S_MLD: begin
                r_mcand  <= {32'd0, w_opa};
                r_mplier <= w_opb;
                r_msg    <= w_osg;
                r_acc    <= '0;
                r_cnt    <= '0;
                r_state  <= S_MUL;
            end
            S_MUL: begin
                r_acc    <= w_acc_next;
                r_mcand  <= {r_mcand[62:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[31:1]};
                r_cnt    <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    unique case (r_k)
                        2'd0:    r_p0 <= w_acc_next;
                        2'd1:    r_p1 <= w_acc_next;
                        default: r_p2 <= w_acc_next;
                    endcase
                    r_sg[r_k] <= r_msg;
                    if (r_k == 2'd2) begin
                        r_state <= S_COMB;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_MLD;
                    end
                end
            end
            S_COMB: begin
                priority if (r_act == ACT_CMP) begin
                    if (w_n == 66'd0) begin
                        r_res.order <= ORD_EQUAL;
                    end else if (w_n[65] ^ w_d[65]) begin
                        r_res.order <= ORD_LESS;
                    end else begin
                        r_res.order <= ORD_GREATER;
                    end
                    r_state <= S_OUT;
                end else if (w_d == 66'd0) begin
                    r_res.status <= ST_ZERO_DEN;
                    r_state      <= S_OUT;
                end else begin
                    r_neg   <= (w_n[65] ^ w_d[65]) && (w_n != 66'd0);
                    r_nm    <= w_nabs[63:0];
                    r_dm    <= w_dabs[63:0];
                    r_x     <= w_nabs[63:0];
                    r_y     <= w_dabs[63:0];
                    r_sh    <= '0;
                    r_state <= S_GCD;
                end
            end
            S_GCD: begin
                priority if (r_x == 64'd0 || r_y == 64'd0) begin
                    r_g     <= ((r_x == 64'd0) ? r_y : r_x) << r_sh;
                    r_q     <= r_nm;
                    r_r     <= '0;
                    r_cnt   <= '0;
                    r_dsel  <= 1'b0;
                    r_state <= S_DIV;
                end else if (!r_x[0] && !r_y[0]) begin
                    r_x  <= r_x >> 1;
                    r_y  <= r_y >> 1;
                    r_sh <= r_sh + 6'd1;
                end else if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else if (r_x >= r_y) begin
                    r_x <= (r_x - r_y) >> 1;
                end else begin
                    r_y <= (r_y - r_x) >> 1;
                end
            end
            S_DIV: begin
                r_r   <= w_ge ? w_rsub : w_rt;
                r_q   <= w_qn;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    if (!r_dsel) begin
                        r_nm   <= w_qn;
                        r_q    <= r_dm;
                        r_r    <= '0;
                        r_dsel <= 1'b1;
                    end else begin
                        r_dm    <= w_qn;
                        r_state <= S_CHK;
                    end
                end
            end
            S_CHK: begin
                if (w_ovf) begin
                    r_res.status <= ST_OVERFLOW;
                end else begin
                    r_res.res_num <= w_resn[31:0];
                    r_res.res_den <= r_dm[30:0];
                end
                r_state <= S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || o_out.ready) begin
                    r_odata  <= r_res;
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
            end
            default: r_state <= S_IDLE;
        endcase
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end
    end

endmodule

@@ tb/sv/rational_arithmetic_unit_tb.sv @@
module rational_arithmetic_unit_tb;
    import rau_pkg::*;

    localparam int WIDTH = 32;

    // scoreboard: predicted results of accepted operations, oldest first
    class rau_scoreboard;
        t_rau_out pending[$];
        int       errors;

        // reduce n/d into a fraction that fits WIDTH, or flag it
        static function t_rau_out reduce_frac(longint n, longint d);
            t_rau_out r;
            logic [63:0] nm, dm, g, x, y, t, lim;
            bit neg;
            r = '0;
            if (d == 0) begin
                r.status = ST_ZERO_DEN;
                return r;
            end
            neg = (n < 0) != (d < 0);
            nm = (n < 0) ? 64'd0 - 64'(n) : 64'(n);
            dm = (d < 0) ? 64'd0 - 64'(d) : 64'(d);
            x = nm;
            y = dm;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            g = x;
            nm = nm / g;
            dm = dm / g;
            if (nm == 0) begin
                neg = 1'b0;
                dm = 64'd1;
            end
            lim = 64'd1 << (WIDTH - 1);
            if (dm > lim - 1 || (neg ? nm > lim : nm > lim - 1)) begin
                r.status = ST_OVERFLOW;
                return r;
            end
            r.res_num = neg ? 32'(64'd0 - nm) : 32'(nm);
            r.res_den = 31'(dm);
            r.status  = ST_OK;
            return r;
        endfunction

        function t_rau_out predict(t_rau_in op);
            t_rau_out r;
            longint an, ad, bn, bd, n, d, diff;
            r = '0;
            an = op.a_num;
            ad = op.a_den;
            bn = op.b_num;
            bd = longint'({1'b0, op.b_den});
            if (op.action > ACT_CMP) return r;
            if (ad == 0 || (op.action != ACT_NORM && bd == 0)) begin
                r.status = ST_ZERO_DEN;
                return r;
            end
            if (op.action == ACT_CMP) begin
                diff = an * bd - bn * ad;
                if (ad < 0) diff = -diff;
                r.order = diff < 0 ? ORD_LESS : (diff == 0 ? ORD_EQUAL : ORD_GREATER);
                return r;
            end
            case (op.action)
                ACT_NORM: begin n = an; d = ad; end
                ACT_ADD:  begin n = an * bd + bn * ad; d = ad * bd; end
                ACT_SUB:  begin n = an * bd - bn * ad; d = ad * bd; end
                ACT_MUL:  begin n = an * bn; d = ad * bd; end
                default:  begin n = an * bd; d = ad * bn; end
            endcase
            return reduce_frac(n, d);
        endfunction

        function void note_input(t_rau_in op);
            pending.push_back(predict(op));
        endfunction

        function void check_result(t_rau_out got);
            t_rau_out exp_r;
            if (pending.size() == 0) begin
                $error("unexpected result %p", got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.res_num !== exp_r.res_num) begin
                $error("res_num exp %0d got %0d", exp_r.res_num, got.res_num);
                errors++;
            end
            if (got.res_den !== exp_r.res_den) begin
                $error("res_den exp %0d got %0d", exp_r.res_den, got.res_den);
                errors++;
            end
            if (got.order !== exp_r.order) begin
                $error("order exp %0d got %0d", exp_r.order, got.order);
                errors++;
            end
            if (got.status !== exp_r.status) begin
                $error("status exp %0d got %0d", exp_r.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    rau_stream_if #(.T(t_rau_in))  in_if ();
    rau_stream_if #(.T(t_rau_out)) out_if ();
    rau_scoreboard sb = new();
    bit hold_sink = 1'b0;
    bit stim_done = 1'b0;

    rational_arithmetic_unit #(.WIDTH(WIDTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
    end

    // note accepted operations and check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) sb.note_input(in_if.data);
        if (i_rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.data);
    end

    // sink stall pattern, with an occasional long hold-off
    initial begin
        int cnt;
        cnt = 0;
        forever begin
            @(posedge i_clk);
            cnt++;
            if (hold_sink) out_if.ready <= 1'b0;
            else if (cnt % 1000 < 300) out_if.ready <= 1'b1;
            else out_if.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // one transaction; valid stays high if the next one follows at once
    task automatic send_op(t_rau_in op);
        in_if.valid <= 1'b1;
        in_if.data  <= op;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic gap(int n);
        if (n > 0) begin
            in_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 20)) - 10);
            3: return 32'($urandom_range(0, 4000)) - 32'd2000;
            4: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic t_rau_in rand_op();
        t_rau_in op;
        logic [31:0] k;
        op.action = ($urandom_range(0, 30) == 0) ? 3'($urandom_range(6, 7))
                                                 : 3'($urandom_range(0, 5));
        op.a_num = rand_word();
        op.a_den = rand_word();
        op.b_num = rand_word();
        op.b_den = 31'(rand_word());
        if ($urandom_range(0, 19) == 0) op.a_den = '0;
        if ($urandom_range(0, 19) == 0) op.b_den = '0;
        // common factors so reduction and equal compares get exercised
        if ($urandom_range(0, 3) == 0) begin
            k = $urandom_range(1, 60);
            op.a_num = 32'($signed($urandom_range(0, 200)) - 100) * k;
            op.a_den = 32'($urandom_range(1, 100)) * k;
            op.b_num = op.a_num;
            op.b_den = 31'(op.a_den);
        end
        return op;
    endfunction

    initial begin
        t_rau_in op;
        t_rau_in dir[$];
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every action, extremes, zero and unnormalized cases
        dir.push_back('{ACT_NORM, 32'sd6, -32'sd4, 32'sd0, 31'd1});
        dir.push_back('{ACT_NORM, 32'sd0, -32'sd7, 32'sd0, 31'd0});
        dir.push_back('{ACT_NORM, 32'sh8000_0000, -32'sd1, 32'sd0, 31'd0});
        dir.push_back('{ACT_NORM, 32'sh8000_0000, 32'sd1, 32'sd0, 31'd0});
        dir.push_back('{ACT_NORM, 32'sd5, 32'sh8000_0000, 32'sd0, 31'd0});
        dir.push_back('{ACT_NORM, 32'sd5, 32'sd0, 32'sd1, 31'd1});
        dir.push_back('{ACT_ADD, 32'sd1, 32'sd2, 32'sd1, 31'd3});
        dir.push_back('{ACT_ADD, 32'sh7fff_ffff, 32'sd1, 32'sd1, 31'd1});
        dir.push_back('{ACT_ADD, 32'sd1, 32'sd2, 32'sd1, 31'd0});
        dir.push_back('{ACT_SUB, 32'sd1, 32'sd2, 32'sd1, 31'd2});
        dir.push_back('{ACT_SUB, 32'sh8000_0000, 32'sd1, 32'sh7fff_ffff, 31'h7fff_ffff});
        dir.push_back('{ACT_MUL, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 31'h7fff_ffff});
        dir.push_back('{ACT_MUL, 32'sd3, -32'sd4, 32'sd8, 31'd9});
        dir.push_back('{ACT_MUL, 32'sh7fff_ffff, 32'sd1, 32'sd2, 31'd1});
        dir.push_back('{ACT_DIV, 32'sd3, 32'sd4, 32'sd0, 31'd5});
        dir.push_back('{ACT_DIV, 32'sd3, 32'sd4, -32'sd9, 31'd8});
        dir.push_back('{ACT_DIV, 32'sh8000_0000, 32'sd1, -32'sd1, 31'd1});
        dir.push_back('{ACT_CMP, 32'sd1, 32'sd2, 32'sd2, 31'd4});
        dir.push_back('{ACT_CMP, 32'sd1, -32'sd2, 32'sd0, 31'd1});
        dir.push_back('{ACT_CMP, 32'sh7fff_ffff, 32'sd1, 32'sh8000_0000, 31'h7fff_ffff});
        dir.push_back('{ACT_CMP, 32'sd1, 32'sd0, 32'sd0, 31'd1});
        dir.push_back('{3'd6, 32'sd1, 32'sd1, 32'sd1, 31'd1});
        dir.push_back('{3'd7, -32'sd1, -32'sd1, -32'sd1, 31'h7fff_ffff});
        foreach (dir[i]) send_op(dir[i]);

        // random bursts with gaps; a long sink hold-off and a drain pause
        for (int n = 0; n < 900; ) begin
            int burst;
            burst = $urandom_range(1, 12);
            for (int j = 0; j < burst && n < 900; j++, n++) begin
                op = rand_op();
                send_op(op);
                if (n == 300) begin
                    fork
                        begin
                            hold_sink = 1'b1;
                            repeat (3000) @(posedge i_clk);
                            hold_sink = 1'b0;
                        end
                    join_none
                end
                if (n == 600) begin
                    // wait for every outstanding result before going on
                    in_if.valid <= 1'b0;
                    @(posedge i_clk);
                    while (sb.pending.size() != 0) @(posedge i_clk);
                end
            end
            if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 400));
        end
        in_if.valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        @(posedge stim_done);
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        if (sb.errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #8000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
src/rau_pkg.sv
src/rau_stream_if.sv
src/rational_arithmetic_unit.sv
tb/sv/rational_arithmetic_unit_tb.sv
